@@ rtl/core/cgts_pkg.sv @@
// ----------------------------------------------------------------------------
// cgts_pkg: shared types and constants of the chunk-grouped task scheduler
// Command codes, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cgts_pkg;

    // Parameter defaults
    localparam int MAX_GROUPS_DEF  = 16;
    localparam int GROUP_DEPTH_DEF = 64;
    localparam int TAG_BITS_DEF    = 16;

    // Fixed field widths
    localparam int TAG_W    = 16;
    localparam int CHUNK_W  = 31;
    localparam int GCOUNT_W = 5;
    localparam int MSZ_W    = 7;
    localparam int MIF_W    = 8;
    localparam int CFG_W    = 8;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 64;

    // Configuration reset values
    localparam logic [MSZ_W-1:0] MSZ_RESET = 7'd8;
    localparam logic [MIF_W-1:0] MIF_RESET = 8'd4;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_FIN = 2'd2,
        CMD_NOP = 2'd3
    } cmd_code_t;

    typedef enum logic {
        REG_MAX_GROUP_SIZE = 1'b0,
        REG_MAX_IN_FLIGHT  = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENQ_CMP,
        ST_ENQ_NEW,
        ST_DEQ_GRP,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;
        logic rd_head;
        logic scan_next;
        logic enq_hit;
        logic enq_new;
        logic enq_drop;
        logic deq_upd;
        logic fin_dec;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      empty;
        logic      full;
        logic      hit;
        logic      scan_more;
        logic      ready;
        logic      out_busy;
    } dp_status_t;

endpackage

@@ rtl/core/cgts_ctrl.sv @@
// ----------------------------------------------------------------------------
// cgts_ctrl: scheduler controller
// Sequences one transfer at a time: dispatch, group scan or update, and the
// hand-off of the result into the output register.
// ----------------------------------------------------------------------------
module cgts_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  cgts_pkg::dp_status_t  status,
    output cgts_pkg::ctrl_cmd_t   cmd
);

    cgts_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cgts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cgts_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cgts_pkg::ST_DISPATCH;
            end
            cgts_pkg::ST_DISPATCH: begin
                unique case (status.cmd)
                    cgts_pkg::CMD_ENQ: begin
                        state_next = status.empty ? cgts_pkg::ST_ENQ_NEW
                                                  : cgts_pkg::ST_ENQ_CMP;
                    end
                    cgts_pkg::CMD_DEQ: begin
                        state_next = status.ready ? cgts_pkg::ST_DEQ_GRP
                                                  : cgts_pkg::ST_FINISH;
                    end
                    default: state_next = cgts_pkg::ST_FINISH;
                endcase
            end
            cgts_pkg::ST_ENQ_CMP: begin
                priority if (status.hit)       state_next = cgts_pkg::ST_FINISH;
                else if (status.scan_more)     state_next = cgts_pkg::ST_ENQ_CMP;
                else if (status.full)          state_next = cgts_pkg::ST_FINISH;
                else                           state_next = cgts_pkg::ST_ENQ_NEW;
            end
            cgts_pkg::ST_ENQ_NEW: state_next = cgts_pkg::ST_FINISH;
            cgts_pkg::ST_DEQ_GRP: state_next = cgts_pkg::ST_FINISH;
            cgts_pkg::ST_FINISH: begin
                if (!status.out_busy) state_next = cgts_pkg::ST_IDLE;
            end
            default: state_next = cgts_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            cgts_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            cgts_pkg::ST_DISPATCH: begin
                unique case (status.cmd)
                    cgts_pkg::CMD_ENQ: cmd.rd_head = !status.empty;
                    cgts_pkg::CMD_DEQ: cmd.rd_head = status.ready;
                    cgts_pkg::CMD_FIN: cmd.fin_dec = 1'b1;
                    default: ;
                endcase
            end
            cgts_pkg::ST_ENQ_CMP: begin
                priority if (status.hit) cmd.enq_hit   = 1'b1;
                else if (status.scan_more) cmd.scan_next = 1'b1;
                else if (status.full)    cmd.enq_drop  = 1'b1;
                else                     cmd.enq_drop  = 1'b0;
            end
            cgts_pkg::ST_ENQ_NEW: cmd.enq_new = 1'b1;
            cgts_pkg::ST_DEQ_GRP: cmd.deq_upd = 1'b1;
            cgts_pkg::ST_FINISH:  cmd.emit    = !status.out_busy;
            default: ;
        endcase
    end

endmodule

@@ rtl/core/cgts_datapath.sv @@
// ----------------------------------------------------------------------------
// cgts_datapath: scheduler storage and arithmetic
// Group table and task store memories, queue pointers, in-flight counter,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module cgts_datapath #(
    parameter int MAX_GROUPS  = cgts_pkg::MAX_GROUPS_DEF,
    parameter int GROUP_DEPTH = cgts_pkg::GROUP_DEPTH_DEF,
    parameter int TAG_BITS    = cgts_pkg::TAG_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [cgts_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [cgts_pkg::IN_W-1:0]     s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cgts_pkg::OUT_W-1:0]    m_tdata,
    output logic [0:0]                    m_tuser,
    input  cgts_pkg::ctrl_cmd_t           cmd,
    output cgts_pkg::dp_status_t          status
);

    localparam int GW = $clog2(MAX_GROUPS);
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int AW = $clog2(GROUP_DEPTH + 1);
    localparam int SW = $clog2(MAX_GROUPS * GROUP_DEPTH);
    localparam int LW = (AW > cgts_pkg::MSZ_W) ? AW : cgts_pkg::MSZ_W;
    localparam int TSIZE = MAX_GROUPS * GROUP_DEPTH;

    typedef struct packed {
        logic                          has;
        logic [cgts_pkg::CHUNK_W-1:0]  chunk;
        logic [AW-1:0]                 acc;
        logic [AW-1:0]                 rdi;
    } grp_entry_t;

    // Latched transfer
    cgts_pkg::cmd_code_t           cmd_reg;
    logic [TAG_BITS-1:0]           tag_reg;
    logic                          has_reg;
    logic [cgts_pkg::CHUNK_W-1:0]  chunk_reg;

    // Queue state and configuration
    logic [GW-1:0]                 head_reg;
    logic [CW-1:0]                 count_reg;
    logic [cgts_pkg::MIF_W-1:0]    infl_reg;
    logic [cgts_pkg::MSZ_W-1:0]    msz_reg;
    logic [cgts_pkg::MIF_W-1:0]    mif_reg;
    logic [GW-1:0]                 scan_slot_reg;
    logic [CW-1:0]                 scan_idx_reg;

    // Memories
    grp_entry_t                    grp_mem [MAX_GROUPS];
    grp_entry_t                    grp_rd_reg;
    logic [TAG_BITS-1:0]           task_mem [TSIZE];
    logic [TAG_BITS-1:0]           task_rd_reg;

    // Result
    logic                          r_valid_reg, r_enq_reg, r_drop_reg, r_has_reg;
    logic [cgts_pkg::CHUNK_W-1:0]  r_chunk_reg;
    logic                          m_tvalid_reg;
    logic [cgts_pkg::OUT_W-1:0]    m_tdata_reg;
    logic                          m_tuser_reg;

    // Combinational
    logic [GW-1:0]                 grp_raddr;
    logic                          grp_we;
    logic [GW-1:0]                 grp_waddr;
    grp_entry_t                    grp_wdata;
    logic                          task_we, task_re;
    logic [SW-1:0]                 task_waddr, task_raddr;
    logic [GW-1:0]                 scan_slot_inc, head_inc, tail_slot;
    logic [GW:0]                   tail_sum;
    logic [LW-1:0]                 lim;
    logic [AW-1:0]                 rdi_inc, rdi_clamp;
    logic [TAG_BITS+cgts_pkg::TAG_W-1:0] tag_wide;
    logic                          ready;

    function automatic logic [GW-1:0] slot_inc(input logic [GW-1:0] s);
        slot_inc = (s == GW'(MAX_GROUPS - 1)) ? '0 : s + GW'(1);
    endfunction

    assign scan_slot_inc = slot_inc(scan_slot_reg);
    assign head_inc      = slot_inc(head_reg);
    assign tail_sum      = (GW+1)'(head_reg) + (GW+1)'(count_reg);
    assign tail_slot     = (tail_sum >= (GW+1)'(MAX_GROUPS))
                         ? GW'(tail_sum - (GW+1)'(MAX_GROUPS)) : GW'(tail_sum);

    // Effective group limit: zero acts as one, clip to the group depth
    always_comb begin
        if (msz_reg == '0) begin
            lim = LW'(1);
        end else if (LW'(msz_reg) > LW'(GROUP_DEPTH)) begin
            lim = LW'(GROUP_DEPTH);
        end else begin
            lim = LW'(msz_reg);
        end
    end

    assign rdi_inc   = grp_rd_reg.rdi + AW'(1);
    assign rdi_clamp = (grp_rd_reg.rdi >= AW'(GROUP_DEPTH))
                     ? AW'(GROUP_DEPTH - 1) : grp_rd_reg.rdi;
    assign ready     = (count_reg != '0) && (infl_reg < mif_reg);

    assign status.cmd       = cmd_reg;
    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == CW'(MAX_GROUPS));
    assign status.hit       = (grp_rd_reg.has == has_reg)
                           && (grp_rd_reg.chunk == chunk_reg)
                           && (LW'(grp_rd_reg.acc) < lim);
    assign status.scan_more = ((CW+1)'(scan_idx_reg) + (CW+1)'(1)) < (CW+1)'(count_reg);
    assign status.ready     = ready;
    assign status.out_busy  = m_tvalid_reg && !m_tready;

    // Memory access selection
    always_comb begin
        grp_raddr  = scan_slot_reg;
        grp_we     = 1'b0;
        grp_waddr  = scan_slot_reg;
        grp_wdata  = grp_rd_reg;
        task_we    = 1'b0;
        task_waddr = SW'(scan_slot_reg) * SW'(GROUP_DEPTH) + SW'(grp_rd_reg.acc);
        task_re    = 1'b0;
        task_raddr = SW'(scan_slot_reg) * SW'(GROUP_DEPTH) + SW'(rdi_clamp);
        if (cmd.rd_head) begin
            grp_raddr = head_reg;
        end else if (cmd.scan_next) begin
            grp_raddr = scan_slot_inc;
        end
        if (cmd.enq_hit) begin
            grp_we        = 1'b1;
            grp_wdata.acc = grp_rd_reg.acc + AW'(1);
            task_we       = 1'b1;
        end
        if (cmd.enq_new) begin
            grp_we          = 1'b1;
            grp_waddr       = tail_slot;
            grp_wdata.has   = has_reg;
            grp_wdata.chunk = chunk_reg;
            grp_wdata.acc   = AW'(1);
            grp_wdata.rdi   = '0;
            task_we         = 1'b1;
            task_waddr      = SW'(tail_slot) * SW'(GROUP_DEPTH);
        end
        if (cmd.deq_upd) begin
            grp_we        = 1'b1;
            grp_wdata.rdi = rdi_inc;
            task_re       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        grp_rd_reg <= grp_mem[grp_raddr];
        if (grp_we) begin
            grp_mem[grp_waddr] <= grp_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (task_re) begin
            task_rd_reg <= task_mem[task_raddr];
        end
        if (task_we) begin
            task_mem[task_waddr] <= tag_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_slot_reg <= grp_raddr;
        if (cmd.latch_in) begin
            tag_reg   <= TAG_BITS'(s_tdata[15:0]);
            has_reg   <= s_tdata[16];
            chunk_reg <= s_tdata[16] ? s_tdata[47:17] : '0;
        end
        if (cmd.rd_head) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_next) begin
            scan_idx_reg <= scan_idx_reg + CW'(1);
        end
        if (cmd.deq_upd) begin
            r_has_reg   <= grp_rd_reg.has;
            r_chunk_reg <= grp_rd_reg.chunk;
        end
    end

    assign tag_wide = {{cgts_pkg::TAG_W{1'b0}}, task_rd_reg};

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg      <= cgts_pkg::CMD_NOP;
            head_reg     <= '0;
            count_reg    <= '0;
            infl_reg     <= '0;
            msz_reg      <= cgts_pkg::MSZ_RESET;
            mif_reg      <= cgts_pkg::MIF_RESET;
            r_valid_reg  <= 1'b0;
            r_enq_reg    <= 1'b0;
            r_drop_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cgts_pkg::reg_index_t'(cfg_addr))
                    cgts_pkg::REG_MAX_GROUP_SIZE: msz_reg <= cfg_wdata[cgts_pkg::MSZ_W-1:0];
                    cgts_pkg::REG_MAX_IN_FLIGHT:  mif_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.latch_in) begin
                cmd_reg     <= cgts_pkg::cmd_code_t'(s_tuser);
                r_valid_reg <= 1'b0;
                r_enq_reg   <= 1'b0;
                r_drop_reg  <= 1'b0;
            end
            if (cmd.enq_hit) begin
                r_enq_reg <= 1'b1;
            end
            if (cmd.enq_new) begin
                r_enq_reg <= 1'b1;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.enq_drop) begin
                r_drop_reg <= 1'b1;
            end
            if (cmd.deq_upd) begin
                r_valid_reg <= 1'b1;
                infl_reg    <= infl_reg + cgts_pkg::MIF_W'(1);
                if (rdi_inc >= grp_rd_reg.acc) begin
                    head_reg  <= head_inc;
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (cmd.fin_dec && infl_reg != '0) begin
                infl_reg <= infl_reg - cgts_pkg::MIF_W'(1);
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= r_valid_reg;
                m_tdata_reg  <= {ready, infl_reg,
                                 cgts_pkg::GCOUNT_W'(count_reg),
                                 r_drop_reg, r_enq_reg,
                                 r_valid_reg ? r_chunk_reg : {cgts_pkg::CHUNK_W{1'b0}},
                                 r_valid_reg && r_has_reg,
                                 r_valid_reg ? tag_wide[cgts_pkg::TAG_W-1:0]
                                             : {cgts_pkg::TAG_W{1'b0}}};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_GROUPS))
        else $error("group count above slot count");

    a_new_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq_new |-> !status.full)
        else $error("new group appended with all slots taken");

    a_deq_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq_upd |-> (count_reg != '0) && (infl_reg < mif_reg))
        else $error("dequeue served while not ready");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_tvalid_reg && !m_tready))
        else $error("output register overwritten while stalled");

    a_deq_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq_upd |=> r_valid_reg)
        else $error("dequeued task not flagged");

endmodule

@@ rtl/core/chunk_grouped_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// chunk_grouped_task_scheduler: ordered queue of chunk-keyed task groups
// Top level joining the scheduler controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the command (enqueue, dequeue request,
//   task finished); s_tdata carries tag, chunk flag and chunk id. Each accepted
//   transfer produces exactly one result transfer on m_*: m_tuser flags a
//   returned task, m_tdata carries the task, enqueue/drop flags and status.
//   Configuration (max_group_size, max_in_flight) is written through
//   cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Sequence:
//   One transfer is processed at a time. Finish, no-op and a refused dequeue
//   pass from dispatch straight to finish; a served dequeue first reads the
//   group table, then the task store. An enqueue scans the groups in order,
//   comparing the key with each until a match, and appends a new group if
//   none matches and a slot is free. The scan through the group table
//   memory takes one entry per cycle. The result is loaded into the output
//   register in the final cycle.
// Reset and stall:
//   aresetn clears the queue, the in-flight count and loads the register
//   defaults; no clearing pass is needed. While m_tready is low the result
//   holds in the output register; the next transfer is still taken and
//   worked, and it waits for the register to drain before its result loads.
// ----------------------------------------------------------------------------
module chunk_grouped_task_scheduler #(
    parameter int MAX_GROUPS  = cgts_pkg::MAX_GROUPS_DEF,
    parameter int GROUP_DEPTH = cgts_pkg::GROUP_DEPTH_DEF,
    parameter int TAG_BITS    = cgts_pkg::TAG_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [cgts_pkg::CFG_W-1:0]  cfg_wdata,
    // Command stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // task_tag[15:0], has_chunk[16], chunk_id[47:17]
    input  logic [cgts_pkg::IN_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [1:0]                  s_tuser,
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_tag[15:0], out_has_chunk[16], out_chunk_id[47:17], enqueued[48],
    // dropped[49], group_count[54:50], in_flight[62:55], ready_res[63]
    output logic [cgts_pkg::OUT_W-1:0]  m_tdata,
    // task_valid[0]
    output logic [0:0]                  m_tuser
);

    cgts_pkg::ctrl_cmd_t  cmd;
    cgts_pkg::dp_status_t status;

    // Sequencer: owns s_tready and steps each transfer through its phases
    cgts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, counters and the output register
    cgts_datapath #(
        .MAX_GROUPS  (MAX_GROUPS),
        .GROUP_DEPTH (GROUP_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
